// ===== hdl/macd_pkg.sv =====
// Shared types and constants for the MACD crossover detector.
// Used by macd_mac, macd_ctrl and macd_crossover_detector; depends on nothing.
package macd_pkg;

    localparam int PRICE_W   = 32;
    localparam int VAL_W     = 33;
    localparam int ALPHA_W   = 17;
    localparam int COEF_W    = ALPHA_W + 1;
    localparam int OPND_W    = VAL_W + 1;
    localparam int PROD_W    = COEF_W + OPND_W;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 72;

    localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST   = 17'd10082;
    localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST   = 17'd4855;
    localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST = 17'd13107;

    localparam logic [CFG_IDX_W-1:0] REG_FAST_ALPHA   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_ALPHA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_ALPHA = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FAST_A,
        ST_FAST_B,
        ST_FAST_W,
        ST_SLOW_B,
        ST_SLOW_W,
        ST_MACD,
        ST_SIG_A,
        ST_SIG_B,
        ST_SIG_W
    } state_t;

    typedef enum logic [2:0] {
        SEL_FAST_X,
        SEL_FAST_E,
        SEL_SLOW_X,
        SEL_SLOW_E,
        SEL_SIG_X,
        SEL_SIG_E
    } opsel_t;

    typedef struct packed {
        logic   accept;
        opsel_t sel;
        logic   mul_en;
        logic   acc_load;
        logic   fast_we;
        logic   slow_we;
        logic   macd_we;
        logic   out_we;
    } ctrl_t;

endpackage

// ===== hdl/macd_mac.sv =====
// Shared multiply-accumulate unit: one 18 x 34 signed multiplier with a product
// register and an accumulator register. Depends on macd_pkg.
module macd_mac
    import macd_pkg::*;
(
    input  logic                     aclk,
    input  logic [ALPHA_W-1:0]       coef,
    input  logic signed [OPND_W-1:0] opnd,
    input  logic                     mul_en,
    input  logic                     acc_load,
    output logic signed [PROD_W-1:0] sum
);

    logic signed [COEF_W-1:0] coef_s;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;

    assign coef_s    = signed'({1'b0, coef});
    assign prod_next = mul_en ? coef_s * opnd : prod_reg;
    assign acc_next  = acc_load ? prod_reg : acc_reg;
    assign sum       = acc_reg + prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

// ===== hdl/macd_ctrl.sv =====
// Sequencer that steps the shared multiplier through the three EMA updates.
// Depends on macd_pkg.
module macd_ctrl
    import macd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  logic  first_sample,
    input  logic  out_busy,
    output logic  s_tready,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = first_sample ? ST_MACD : ST_FAST_A;
                end
            end
            ST_FAST_A: state_next = ST_FAST_B;
            ST_FAST_B: state_next = ST_FAST_W;
            ST_FAST_W: state_next = ST_SLOW_B;
            ST_SLOW_B: state_next = ST_SLOW_W;
            ST_SLOW_W: state_next = ST_MACD;
            ST_MACD:   state_next = ST_SIG_A;
            ST_SIG_A:  state_next = ST_SIG_B;
            ST_SIG_B:  state_next = ST_SIG_W;
            ST_SIG_W: begin
                if (!out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        ctrl     = '{accept: 1'b0, sel: SEL_FAST_X, mul_en: 1'b0, acc_load: 1'b0,
                     fast_we: 1'b0, slow_we: 1'b0, macd_we: 1'b0, out_we: 1'b0};
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                ctrl.accept = s_tvalid;
            end
            ST_FAST_A: begin
                ctrl.sel    = SEL_FAST_X;
                ctrl.mul_en = 1'b1;
            end
            ST_FAST_B: begin
                ctrl.sel      = SEL_FAST_E;
                ctrl.mul_en   = 1'b1;
                ctrl.acc_load = 1'b1;
            end
            ST_FAST_W: begin
                ctrl.fast_we = 1'b1;
                ctrl.sel     = SEL_SLOW_X;
                ctrl.mul_en  = 1'b1;
            end
            ST_SLOW_B: begin
                ctrl.sel      = SEL_SLOW_E;
                ctrl.mul_en   = 1'b1;
                ctrl.acc_load = 1'b1;
            end
            ST_SLOW_W: begin
                ctrl.slow_we = 1'b1;
            end
            ST_MACD: begin
                ctrl.macd_we = 1'b1;
            end
            ST_SIG_A: begin
                ctrl.sel    = SEL_SIG_X;
                ctrl.mul_en = 1'b1;
            end
            ST_SIG_B: begin
                ctrl.sel      = SEL_SIG_E;
                ctrl.mul_en   = 1'b1;
                ctrl.acc_load = 1'b1;
            end
            ST_SIG_W: begin
                ctrl.out_we = !out_busy;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/macd_crossover_detector.sv =====
// Top level of the MACD signal-line crossover detector: registers, operand
// selection and result word. Depends on macd_pkg, macd_mac and macd_ctrl.
//
//   Channel  Ports                         Word contents
//   input    s_tvalid s_tready s_tdata     close_price
//   result   m_tvalid m_tready m_tdata     macd_value, signal_value, buy, sell
//   config   cfg_valid cfg_ready           cfg_index, cfg_data (always ready)
//
// A word is accepted, then passes through nine sequencer steps, six of which
// drive the single shared 18 x 34 multiplier. The first word after reset skips
// the fast and slow EMA steps, as both EMAs are simply loaded with the price.
// Reset restores the default smoothing factors and clears all EMA state.
// A new word is accepted while a result waits; the last step holds until the
// result register is free.
module macd_crossover_detector
    import macd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] close_price
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [32:0] macd_value, [65:33] signal_value,
                                            // [66] buy_flag, [67] sell_flag, [71:68] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ALPHA_W-1:0]   cfg_data
);

    ctrl_t ctrl;

    logic [ALPHA_W-1:0] fast_alpha_reg, fast_alpha_next;
    logic [ALPHA_W-1:0] slow_alpha_reg, slow_alpha_next;
    logic [ALPHA_W-1:0] sig_alpha_reg, sig_alpha_next;
    logic [ALPHA_W-1:0] cfg_clamped;

    logic                     first_reg, first_next;
    logic [PRICE_W-1:0]       price_reg, price_next;
    logic [PRICE_W-1:0]       fast_reg, fast_next;
    logic [PRICE_W-1:0]       slow_reg, slow_next;
    logic signed [VAL_W-1:0]  macd_reg, macd_next;
    logic signed [VAL_W-1:0]  sig_reg, sig_next;
    logic signed [VAL_W-1:0]  prev_macd_reg, prev_macd_next;
    logic signed [VAL_W-1:0]  prev_sig_reg, prev_sig_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;

    logic [ALPHA_W-1:0]       coef;
    logic signed [OPND_W-1:0] opnd;
    logic signed [PROD_W-1:0] sum;
    logic signed [VAL_W-1:0]  sig_new;
    logic                     buy;
    logic                     sell;
    logic                     out_busy;

    assign cfg_ready = 1'b1;

    assign out_busy = m_tvalid_reg && !m_tready;

    macd_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .first_sample (first_reg),
        .out_busy     (out_busy),
        .s_tready     (s_tready),
        .ctrl         (ctrl)
    );

    macd_mac u_mac (
        .aclk     (aclk),
        .coef     (coef),
        .opnd     (opnd),
        .mul_en   (ctrl.mul_en),
        .acc_load (ctrl.acc_load),
        .sum      (sum)
    );

    always_comb begin
        coef = fast_alpha_reg;
        opnd = signed'({2'b00, price_reg});
        unique case (ctrl.sel)
            SEL_FAST_X: begin
                coef = fast_alpha_reg;
                opnd = signed'({2'b00, price_reg});
            end
            SEL_FAST_E: begin
                coef = ONE_Q16 - fast_alpha_reg;
                opnd = signed'({2'b00, fast_reg});
            end
            SEL_SLOW_X: begin
                coef = slow_alpha_reg;
                opnd = signed'({2'b00, price_reg});
            end
            SEL_SLOW_E: begin
                coef = ONE_Q16 - slow_alpha_reg;
                opnd = signed'({2'b00, slow_reg});
            end
            SEL_SIG_X: begin
                coef = sig_alpha_reg;
                opnd = signed'({macd_reg[VAL_W-1], macd_reg});
            end
            SEL_SIG_E: begin
                coef = ONE_Q16 - sig_alpha_reg;
                opnd = signed'({sig_reg[VAL_W-1], sig_reg});
            end
            default: begin
                coef = fast_alpha_reg;
                opnd = signed'({2'b00, price_reg});
            end
        endcase
    end

    assign sig_new = sum[FRAC_W+VAL_W-1:FRAC_W];
    assign buy     = (prev_sig_reg > prev_macd_reg) && (sig_new < macd_reg);
    assign sell    = !buy && (prev_sig_reg < prev_macd_reg) && (sig_new > macd_reg);

    assign cfg_clamped = (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;

    always_comb begin
        fast_alpha_next = fast_alpha_reg;
        slow_alpha_next = slow_alpha_reg;
        sig_alpha_next  = sig_alpha_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_FAST_ALPHA:   fast_alpha_next = cfg_clamped;
                REG_SLOW_ALPHA:   slow_alpha_next = cfg_clamped;
                REG_SIGNAL_ALPHA: sig_alpha_next  = cfg_clamped;
                default:          fast_alpha_next = fast_alpha_reg;
            endcase
        end
    end

    always_comb begin
        first_next     = first_reg;
        price_next     = price_reg;
        fast_next      = fast_reg;
        slow_next      = slow_reg;
        macd_next      = macd_reg;
        sig_next       = sig_reg;
        prev_macd_next = prev_macd_reg;
        prev_sig_next  = prev_sig_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        if (ctrl.accept) begin
            price_next    = s_tdata;
            prev_sig_next = sig_reg;
            if (first_reg) begin
                first_next = 1'b0;
                fast_next  = s_tdata;
                slow_next  = s_tdata;
            end else begin
                prev_macd_next = macd_reg;
            end
        end
        if (ctrl.fast_we) begin
            fast_next = sum[FRAC_W+PRICE_W-1:FRAC_W];
        end
        if (ctrl.slow_we) begin
            slow_next = sum[FRAC_W+PRICE_W-1:FRAC_W];
        end
        if (ctrl.macd_we) begin
            macd_next = signed'({1'b0, fast_reg}) - signed'({1'b0, slow_reg});
        end
        if (ctrl.out_we) begin
            sig_next      = sig_new;
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0000, sell, buy, sig_new, macd_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_alpha_reg <= FAST_ALPHA_RST;
            slow_alpha_reg <= SLOW_ALPHA_RST;
            sig_alpha_reg  <= SIGNAL_ALPHA_RST;
            first_reg      <= 1'b1;
            fast_reg       <= '0;
            slow_reg       <= '0;
            macd_reg       <= '0;
            sig_reg        <= '0;
            prev_macd_reg  <= '0;
            prev_sig_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            fast_alpha_reg <= fast_alpha_next;
            slow_alpha_reg <= slow_alpha_next;
            sig_alpha_reg  <= sig_alpha_next;
            first_reg      <= first_next;
            fast_reg       <= fast_next;
            slow_reg       <= slow_next;
            macd_reg       <= macd_next;
            sig_reg        <= sig_next;
            prev_macd_reg  <= prev_macd_next;
            prev_sig_reg   <= prev_sig_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        price_reg   <= price_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_we |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten before it was taken");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[66] && m_tdata[67]))
        else $error("buy and sell raised together");

endmodule

// ===== verif/tb_macd_crossover_detector.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for macd_crossover_detector. Price words are streamed in under
// random idling and back-pressure, and each result word is checked against a local model.
// Depends on macd_pkg and the detector RTL.
module tb_macd_crossover_detector;
    import macd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic signed [VAL_W-1:0] macd;
        logic signed [VAL_W-1:0] sig_line;
        logic                    buy;
        logic                    sell;
    } macd_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ALPHA_W-1:0]   cfg_data = '0;

    macd_crossover_detector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Local copy of the detector state and smoothing factors.
    logic [ALPHA_W-1:0]      fast_alpha = FAST_ALPHA_RST;
    logic [ALPHA_W-1:0]      slow_alpha = SLOW_ALPHA_RST;
    logic [ALPHA_W-1:0]      signal_alpha = SIGNAL_ALPHA_RST;
    logic                    first_bar = 1'b1;
    logic [PRICE_W-1:0]      fast_ema = '0;
    logic [PRICE_W-1:0]      slow_ema = '0;
    logic signed [VAL_W-1:0] signal_ema = '0;
    logic signed [VAL_W-1:0] last_macd = '0;

    macd_word_t pending_words[$];

    int  mismatches = 0;
    int  words_sent = 0;
    int  reg_writes = 0;
    int  results_seen = 0;
    int  buys_seen = 0;
    int  sells_seen = 0;
    bit  quiet = 1'b0;
    int  hold_requests = 0;
    int  holds_served = 0;
    int  hold_left = 0;

    longint walk_level = 64'h0000_0000_0064_0000;
    int     walk_trend = 0;

    function automatic logic [PRICE_W-1:0] ema_price(logic [PRICE_W-1:0] x,
                                                     logic [PRICE_W-1:0] e,
                                                     logic [ALPHA_W-1:0] a);
        longint unsigned k;
        longint unsigned acc;
        k = (a > ONE_Q16) ? 64'd65536 : 64'(a);
        acc = k * 64'(x) + (64'd65536 - k) * 64'(e);
        return acc[47:16];
    endfunction

    function automatic logic signed [VAL_W-1:0] ema_macd(logic signed [VAL_W-1:0] x,
                                                         logic signed [VAL_W-1:0] e,
                                                         logic [ALPHA_W-1:0] a);
        longint k;
        longint acc;
        k = (a > ONE_Q16) ? 64'sd65536 : longint'(a);
        acc = k * longint'(x) + (64'sd65536 - k) * longint'(e);
        acc = acc >>> FRAC_W;
        return acc[VAL_W-1:0];
    endfunction

    function automatic void predict_crossing(logic [PRICE_W-1:0] price);
        logic signed [VAL_W-1:0] macd_now;
        logic signed [VAL_W-1:0] signal_before;
        macd_word_t w;
        if (first_bar) begin
            fast_ema = price;
            slow_ema = price;
            first_bar = 1'b0;
        end else begin
            last_macd = $signed({1'b0, fast_ema}) - $signed({1'b0, slow_ema});
            fast_ema = ema_price(price, fast_ema, fast_alpha);
            slow_ema = ema_price(price, slow_ema, slow_alpha);
        end
        macd_now = $signed({1'b0, fast_ema}) - $signed({1'b0, slow_ema});
        signal_before = signal_ema;
        signal_ema = ema_macd(macd_now, signal_ema, signal_alpha);
        w.macd = macd_now;
        w.sig_line = signal_ema;
        w.buy = (signal_before > last_macd) && (signal_ema < macd_now);
        w.sell = !w.buy && (signal_before < last_macd) && (signal_ema > macd_now);
        pending_words.push_back(w);
    endfunction

    // Trending random walk with occasional spikes that leave the walk untouched.
    function automatic logic [PRICE_W-1:0] next_price();
        longint step;
        if ($urandom_range(19) == 0)
            return $urandom();
        if ($urandom_range(11) == 0)
            walk_trend = int'($urandom_range(1 << 19)) - (1 << 18);
        if ($urandom_range(199) == 0)
            walk_level = longint'($urandom());
        step = longint'(walk_trend) + longint'($urandom_range(1 << 17)) - (1 << 16);
        walk_level = walk_level + step;
        if (walk_level < 0)
            walk_level = 0;
        if (walk_level > 64'h0000_0000_FFFF_FFFF)
            walk_level = 64'h0000_0000_FFFF_FFFF;
        return walk_level[PRICE_W-1:0];
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        case ($urandom_range(9))
            0: return '0;
            1: return ONE_Q16;
            2: return ALPHA_W'($urandom_range(65537, 131071));
            default: return ALPHA_W'($urandom_range(1, 40000));
        endcase
    endfunction

    task automatic send_price(logic [PRICE_W-1:0] price);
        if (!quiet && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (!quiet && $urandom_range(99) < 31);
        end
        s_tvalid <= 1'b1;
        s_tdata <= price;
        do @(posedge aclk); while (!s_tready);
        predict_crossing(price);
        words_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ALPHA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FAST_ALPHA:   fast_alpha = value;
            REG_SLOW_ALPHA:   slow_alpha = value;
            REG_SIGNAL_ALPHA: signal_alpha = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_alphas(logic [ALPHA_W-1:0] f, logic [ALPHA_W-1:0] s,
                              logic [ALPHA_W-1:0] g);
        write_reg(REG_FAST_ALPHA, f);
        write_reg(REG_SLOW_ALPHA, s);
        write_reg(REG_SIGNAL_ALPHA, g);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_words.size() != 0) begin
            $display("%0d result words never arrived", pending_words.size());
            mismatches += pending_words.size();
            pending_words.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive_ready
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 31);
        end
    end

    always @(posedge aclk) begin : check_results
        macd_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tdata[66])
                buys_seen++;
            if (m_tdata[67])
                sells_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %0d: macd %0d signal %0d", results_seen,
                             $signed(m_tdata[32:0]), $signed(m_tdata[65:33]));
            end else begin
                w = pending_words.pop_front();
                if (m_tdata[32:0] !== w.macd || m_tdata[65:33] !== w.sig_line ||
                    m_tdata[66] !== w.buy || m_tdata[67] !== w.sell) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result word %0d: expected macd %0d signal %0d",
                                 results_seen, w.macd, w.sig_line,
                                 " buy %0b sell %0b,", w.buy, w.sell,
                                 " got macd %0d signal %0d",
                                 $signed(m_tdata[32:0]), $signed(m_tdata[65:33]),
                                 " buy %0b sell %0b", m_tdata[66], m_tdata[67]);
                end
            end
        end
    end

    task automatic test_first_and_extremes();
        logic [PRICE_W-1:0] prices[14];
        prices = '{32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000,
                   32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0050_0000,
                   32'h0048_0000, 32'h0040_0000, 32'h0060_0000, 32'h0080_0000,
                   32'h00A0_0000, 32'h0070_0000};
        foreach (prices[i])
            send_price(prices[i]);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_SPARE, 17'h15555);
        set_alphas(ONE_Q16, '0, 17'h1FFFF);
        send_price(32'h1234_5678);
        send_price(32'h8765_4321);
        send_price(32'h0000_FFFF);
        wait_idle();
        set_alphas('0, 17'h10001, '0);
        send_price(32'hFFFF_0000);
        send_price(32'h0001_0000);
        send_price(32'h7FFF_FFFF);
        wait_idle();
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        hold_requests++;
        repeat (16)
            send_price(next_price());
        wait_idle();
        quiet = 1'b0;
    endtask

    task automatic test_random_runs();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0)
                set_alphas(FAST_ALPHA_RST, SLOW_ALPHA_RST, SIGNAL_ALPHA_RST);
            else
                set_alphas(pick_alpha(), pick_alpha(), pick_alpha());
            quiet = (phase == 3);
            repeat (200)
                send_price(next_price());
            wait_idle();
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_and_extremes();
        test_register_extremes();
        test_backpressure();
        test_random_runs();
        wait_idle();
        $display("Streamed %0d price words across %0d register writes, spare index included.",
                 words_sent, reg_writes);
        $display("Checked %0d result words with %0d buy and %0d sell crossings.",
                 results_seen, buys_seen, sells_seen);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/macd_pkg.sv
hdl/macd_mac.sv
hdl/macd_ctrl.sv
hdl/macd_crossover_detector.sv
verif/tb_macd_crossover_detector.sv
